[rtl/core/tts_pkg.sv]
// ----------------------------------------------------------------------------
// tts_pkg
// Types, codes and restore values shared by the tick row sequencer files.
// ----------------------------------------------------------------------------
package tts_pkg;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_IDLE  = 2'd1,
    ACT_ARMED = 2'd2,
    ACT_JUMP  = 2'd3
  } tts_action_t;

  typedef enum logic [1:0] {
    REG_ROW_LIMIT   = 2'd0,
    REG_STEP_LIMIT  = 2'd1,
    REG_LOOP_STEP   = 2'd2,
    REG_STOP_AT_END = 2'd3
  } tts_reg_t;

  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 16;

  localparam logic [15:0] ROW_LIMIT_RESET  = 16'd64;
  localparam logic [15:0] STEP_LIMIT_RESET = 16'd1;
  localparam logic [15:0] LOOP_STEP_RESET  = 16'd0;

  localparam logic [15:0] STEP_RESTORE  = 16'hFFFF;
  localparam logic [15:0] ROW_RESTORE   = 16'h4E20;
  localparam logic [15:0] SPEED_RESTORE = 16'd6;
  localparam logic [7:0]  HOLD_ARMED    = 8'd2;

  typedef struct packed {
    logic [15:0] row_limit;
    logic [15:0] step_limit;
    logic [15:0] loop_step;
    logic        stop_at_end;
  } tts_cfg_t;

  typedef struct packed {
    logic [31:0] last_tick;
    logic        armed;
    logic [7:0]  hold_count;
    logic [15:0] step_count;
    logic [15:0] row_count;
    logic [15:0] speed_word;
    logic [7:0]  tick_count;
    logic        advanced;
    logic        wrapped;
    logic        song_end;
    logic        jump_pending;
  } tts_state_t;

  typedef struct packed {
    logic        row_advanced;
    logic        row_wrapped;
    logic        song_end;
    logic [15:0] row;
    logic [15:0] step;
    logic [15:0] speed;
    logic [7:0]  tick_countdown;
    logic [7:0]  hold_countdown;
    logic        armed;
  } tts_result_t;

  function automatic tts_state_t tts_restore(input tts_state_t s);
    tts_state_t r;
    r              = s;
    r.step_count   = STEP_RESTORE;
    r.row_count    = ROW_RESTORE;
    r.speed_word   = SPEED_RESTORE;
    r.tick_count   = 8'd0;
    r.advanced     = 1'b0;
    r.wrapped      = 1'b0;
    r.jump_pending = 1'b0;
    return r;
  endfunction

  function automatic tts_state_t tts_state_reset();
    tts_state_t r;
    r            = '0;
    r            = tts_restore(r);
    return r;
  endfunction

endpackage

[rtl/core/tts_if.sv]
// ----------------------------------------------------------------------------
// tts_if
// Request and result channels of the tick row sequencer.
// ----------------------------------------------------------------------------
interface tts_tick_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] tick_id;

  modport source (output valid, output action, output tick_id, input ready);
  modport sink (input valid, input action, input tick_id, output ready);
endinterface

interface tts_result_if;
  logic        valid;
  logic        ready;
  logic        row_advanced;
  logic        row_wrapped;
  logic        song_end;
  logic [15:0] row;
  logic [15:0] step;
  logic [15:0] speed;
  logic [7:0]  tick_countdown;
  logic [7:0]  hold_countdown;
  logic        armed;

  modport source (
    output valid, output row_advanced, output row_wrapped, output song_end,
    output row, output step, output speed, output tick_countdown,
    output hold_countdown, output armed, input ready
  );
  modport sink (
    input valid, input row_advanced, input row_wrapped, input song_end,
    input row, input step, input speed, input tick_countdown,
    input hold_countdown, input armed, output ready
  );
endinterface

[rtl/core/tts_update.sv]
// ----------------------------------------------------------------------------
// tts_update
// Next sequencer state for one request: resets, jump arming and tick rows.
// ----------------------------------------------------------------------------
module tts_update
  import tts_pkg::*;
(
  input  tts_state_t  cur,
  input  tts_cfg_t    cfg,
  input  logic [1:0]  action,
  input  logic [31:0] tick_id,
  output tts_state_t  nxt
);

  tts_action_t act;
  logic        row_tick;
  logic [15:0] row_adv;
  logic [15:0] speed_sw;
  logic [15:0] step_inc;
  logic        row_at_limit;
  logic        step_at_limit;
  tts_state_t  t;

  assign act      = tts_action_t'(action);
  assign row_tick = (cur.speed_word[7:0] != 8'd0) && (cur.tick_count == 8'd0);
  assign row_adv  = cur.jump_pending ? cfg.row_limit : cur.row_count + 16'd1;
  // swing: swap the speed bytes whenever the alternate byte is set
  assign speed_sw = (cur.speed_word[15:8] != 8'd0) ?
                    {cur.speed_word[7:0], cur.speed_word[15:8]} : cur.speed_word;
  assign step_inc = cur.step_count + 16'd1;
  // signed counter against unsigned limit: negative never reaches it
  assign row_at_limit  = !row_adv[15] && (row_adv >= cfg.row_limit);
  assign step_at_limit = !step_inc[15] && (step_inc >= cfg.step_limit);

  always_comb begin
    t = cur;
    if (row_tick) begin
      t.jump_pending = 1'b0;
      t.row_count    = row_adv;
      t.speed_word   = speed_sw;
      t.tick_count   = speed_sw[7:0] - 8'd1;
      if (row_at_limit) begin
        t.row_count  = 16'd0;
        t.wrapped    = 1'b1;
        t.step_count = step_inc;
        if (step_at_limit) begin
          if (cfg.stop_at_end) begin
            t.armed      = 1'b0;
            t.speed_word = 16'd0;
          end
          t.song_end   = 1'b1;
          t.step_count = cfg.loop_step;
        end
      end else begin
        t.wrapped = 1'b0;
      end
      t.advanced = 1'b1;
    end else begin
      t.tick_count = cur.tick_count - 8'd1;
      t.advanced   = 1'b0;
    end
    if (t.speed_word[7:0] == 8'd0) begin
      t.song_end = 1'b1;
    end
    t.last_tick = tick_id;
    if (cur.hold_count != 8'd0) begin
      t.hold_count = cur.hold_count - 8'd1;
    end

    case (act)
      ACT_TICK: begin
        if ((cur.last_tick != tick_id) && cur.armed) begin
          nxt = t;
        end else begin
          nxt = cur;
        end
      end
      ACT_IDLE: begin
        nxt = tts_state_reset();
      end
      ACT_ARMED: begin
        nxt            = tts_restore(cur);
        nxt.hold_count = HOLD_ARMED;
        nxt.armed      = 1'b1;
      end
      ACT_JUMP: begin
        nxt              = cur;
        nxt.jump_pending = 1'b1;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

[rtl/core/tracker_tick_row_sequencer.sv]
// ----------------------------------------------------------------------------
// tracker_tick_row_sequencer
// Tick driven row and step sequencer with swing, one request per cycle while the result queue has room.
// ----------------------------------------------------------------------------
// an accepted request is held in the input stage register, then its result is written to the result queue and offered
// throughput: one request per cycle while the result queue is not full; the state update sits in one stage
// a two-entry result queue keeps requests flowing while results are stalled, until it is full
// reset: rst clears the stage and queue, restores counters and loads the
// register defaults (row limit 64, step limit 1, loop step 0, no stop)
module tracker_tick_row_sequencer
  import tts_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  tts_tick_if.sink                 tick,
  tts_result_if.source             result,
  input  logic                     wr_en,
  input  logic [CfgIndexWidth-1:0] wr_index,
  input  logic [CfgDataWidth-1:0]  wr_data
);

  tts_cfg_t    cfg;
  tts_state_t  st;
  tts_state_t  st_next;

  logic        s1_valid;
  logic [1:0]  s1_action;
  logic [31:0] s1_tick_id;
  logic        s1_go;

  tts_result_t q0;
  tts_result_t q1;
  logic [1:0]  q_cnt;
  logic        push;
  logic        pop;
  logic [1:0]  wr_slot;
  tts_result_t res_new;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_limit   <= ROW_LIMIT_RESET;
      cfg.step_limit  <= STEP_LIMIT_RESET;
      cfg.loop_step   <= LOOP_STEP_RESET;
      cfg.stop_at_end <= 1'b0;
    end else if (wr_en) begin
      case (tts_reg_t'(wr_index))
        REG_ROW_LIMIT:   cfg.row_limit   <= wr_data;
        REG_STEP_LIMIT:  cfg.step_limit  <= wr_data;
        REG_LOOP_STEP:   cfg.loop_step   <= wr_data;
        REG_STOP_AT_END: cfg.stop_at_end <= wr_data[0];
        default: begin
        end
      endcase
    end
  end

  // input stage
  assign s1_go      = s1_valid && (q_cnt != 2'd2);
  assign tick.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick.ready) begin
      s1_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      s1_action  <= tick.action;
      s1_tick_id <= tick.tick_id;
    end
  end

  tts_update u_update (
    .cur     (st),
    .cfg     (cfg),
    .action  (s1_action),
    .tick_id (s1_tick_id),
    .nxt     (st_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= tts_state_reset();
    end else if (s1_go) begin
      st <= st_next;
    end
  end

  always_comb begin
    res_new.row_advanced   = st_next.advanced;
    res_new.row_wrapped    = st_next.wrapped;
    res_new.song_end       = st_next.song_end;
    res_new.row            = st_next.row_count;
    res_new.step           = st_next.step_count;
    res_new.speed          = st_next.speed_word;
    res_new.tick_countdown = st_next.tick_count;
    res_new.hold_countdown = st_next.hold_count;
    res_new.armed          = st_next.armed;
  end

  // result queue, head in q0
  assign push    = s1_go;
  assign pop     = result.valid && result.ready;
  assign wr_slot = q_cnt - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      q_cnt <= 2'd0;
    end else begin
      q_cnt <= q_cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      q0 <= q1;
    end
    if (push) begin
      if (wr_slot == 2'd0) begin
        q0 <= res_new;
      end else begin
        q1 <= res_new;
      end
    end
  end

  assign result.valid          = (q_cnt != 2'd0);
  assign result.row_advanced   = q0.row_advanced;
  assign result.row_wrapped    = q0.row_wrapped;
  assign result.song_end       = q0.song_end;
  assign result.row            = q0.row;
  assign result.step           = q0.step;
  assign result.speed          = q0.speed;
  assign result.tick_countdown = q0.tick_countdown;
  assign result.hold_countdown = q0.hold_countdown;
  assign result.armed          = q0.armed;

endmodule
